@@ sv/crp_pkg.sv @@
// ----------------------------------------------------------------------------
// crp_pkg
// Word types and fixed constants for the column rectangle packer.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned COORD_W = 16;

    localparam logic [COORD_W-1:0] MAX_HEIGHT_RESET = 16'd4096;

    typedef struct packed {
        logic [DIM_W-1:0] item_width;
        logic [DIM_W-1:0] item_height;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] place_x;
        logic [COORD_W-1:0] place_y;
        logic [COORD_W-1:0] atlas_width;
        logic [COORD_W-1:0] atlas_height;
        logic               no_room;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [DIM_W-1:0]   span;
        logic [COORD_W-1:0] bottom;
    } column_t;

endpackage

@@ sv/column_rect_packer.sv @@
// ----------------------------------------------------------------------------
// column_rect_packer
// Column packer: places each rectangle on a matching column stack or opens a
// new column to the right (or flags no_room), and reports placement and atlas size.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result word appears. The result is shown on result for exactly one
// cycle with done high, and the receiver cannot stall it. The first word after
// reset opens column 0 at once with no scan; a later word scans the column
// table up to the first match or the last column, through its single read port,
// one column per cycle, with the compare working on the registered read data.
// cfg_we/cfg_data write max_height; the user must do so only while busy is low,
// as the block itself does not enforce it.
module column_rect_packer #(
    parameter int unsigned MAX_COLUMNS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  crp_pkg::item_t                item,
    output logic                          done,
    output crp_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [crp_pkg::COORD_W-1:0]   cfg_data
);

    localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_COLUMNS);
    localparam logic [CW-1:0] ONE        = CW'(1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                        state_reg,      state_next;
    logic [CW-1:0]                 addr_reg,       addr_next;
    logic [CW-1:0]                 cmp_idx_reg,    cmp_idx_next;
    logic                          pend_reg,       pend_next;
    logic [CW-1:0]                 count_reg,      count_next;
    logic [crp_pkg::COORD_W-1:0]   atlas_w_reg,    atlas_w_next;
    logic [crp_pkg::COORD_W-1:0]   atlas_h_reg,    atlas_h_next;
    logic [crp_pkg::COORD_W-1:0]   max_height_reg, max_height_next;
    logic                          done_reg,       done_next;
    crp_pkg::result_t              result_reg,     result_next;
    crp_pkg::item_t                item_reg,       item_next;

    crp_pkg::column_t              col_mem [MAX_COLUMNS];
    crp_pkg::column_t              rd_data_reg;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    crp_pkg::column_t              wr_data;

    logic [crp_pkg::COORD_W:0]     top;
    logic [crp_pkg::COORD_W:0]     right;
    logic                          match;
    logic                          cmp_last;

    assign top = {1'b0, rd_data_reg.bottom}
               + {{(crp_pkg::COORD_W + 1 - crp_pkg::DIM_W){1'b0}}, item_reg.item_height};
    assign right = {1'b0, atlas_w_reg}
                 + {{(crp_pkg::COORD_W + 1 - crp_pkg::DIM_W){1'b0}}, item_reg.item_width};
    assign match = (rd_data_reg.span == item_reg.item_width)
                && (top <= {1'b0, max_height_reg})
                && ((atlas_w_reg >= atlas_h_reg) || (top <= {1'b0, atlas_h_reg}));
    assign cmp_last = (cmp_idx_reg == (count_reg - ONE));

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = 1'b0;
        count_next      = count_reg;
        atlas_w_next    = atlas_w_reg;
        atlas_h_next    = atlas_h_reg;
        max_height_next = cfg_we ? cfg_data : max_height_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        item_next       = item_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    addr_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    // open column 0 at the origin, no height check
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    wr_data.left   = '0;
                    wr_data.span   = item_reg.item_width;
                    wr_data.bottom = {{(crp_pkg::COORD_W - crp_pkg::DIM_W){1'b0}},
                                      item_reg.item_height};
                    count_next     = ONE;
                    atlas_w_next   = {{(crp_pkg::COORD_W - crp_pkg::DIM_W){1'b0}},
                                      item_reg.item_width};
                    atlas_h_next   = wr_data.bottom;
                    result_next.place_x      = '0;
                    result_next.place_y      = '0;
                    result_next.atlas_width  = atlas_w_next;
                    result_next.atlas_height = atlas_h_next;
                    result_next.no_room      = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (pend_reg && match)
                begin
                    // stack on this column
                    wr_en          = 1'b1;
                    wr_addr        = cmp_idx_reg[AW-1:0];
                    wr_data        = rd_data_reg;
                    wr_data.bottom = top[crp_pkg::COORD_W-1:0];
                    if ({1'b0, atlas_h_reg} < top)
                    begin
                        atlas_h_next = top[crp_pkg::COORD_W-1:0];
                    end
                    result_next.place_x      = rd_data_reg.left;
                    result_next.place_y      = rd_data_reg.bottom;
                    result_next.atlas_width  = atlas_w_reg;
                    result_next.atlas_height = atlas_h_next;
                    result_next.no_room      = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (pend_reg && cmp_last)
                begin
                    // no column fits: open a new one on the right, or flag no_room if none can open
                    result_next.place_x = '0;
                    result_next.place_y = '0;
                    if ((count_reg == COUNT_FULL) || right[crp_pkg::COORD_W])
                    begin
                        result_next.no_room = 1'b1;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = count_reg[AW-1:0];
                        wr_data.left   = atlas_w_reg;
                        wr_data.span   = item_reg.item_width;
                        wr_data.bottom = {{(crp_pkg::COORD_W - crp_pkg::DIM_W){1'b0}},
                                          item_reg.item_height};
                        count_next     = count_reg + ONE;
                        atlas_w_next   = right[crp_pkg::COORD_W-1:0];
                        if (atlas_h_reg < wr_data.bottom)
                        begin
                            atlas_h_next = wr_data.bottom;
                        end
                        result_next.place_x = atlas_w_reg;
                        result_next.no_room = 1'b0;
                    end
                    result_next.atlas_width  = atlas_w_next;
                    result_next.atlas_height = atlas_h_next;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (addr_reg < count_reg)
                begin
                    // advance the read one column ahead of the compare
                    pend_next    = 1'b1;
                    cmp_idx_next = addr_reg;
                    addr_next    = addr_reg + ONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            cmp_idx_reg    <= '0;
            pend_reg       <= 1'b0;
            count_reg      <= '0;
            atlas_w_reg    <= '0;
            atlas_h_reg    <= '0;
            max_height_reg <= crp_pkg::MAX_HEIGHT_RESET;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            item_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            cmp_idx_reg    <= cmp_idx_next;
            pend_reg       <= pend_next;
            count_reg      <= count_next;
            atlas_w_reg    <= atlas_w_next;
            atlas_h_reg    <= atlas_h_next;
            max_height_reg <= max_height_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            item_reg       <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= col_mem[addr_reg[AW-1:0]];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held over two cycles");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_room) |-> (result.place_x == '0 && result.place_y == '0))
        else $error("refused word carries a placement");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("column count past table depth");

endmodule
